// ===== src/esd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // Decoder modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_OCTAL  = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  // Character codes.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_LC_A      = 8'h61;
  localparam logic [7:0] CH_LC_B      = 8'h62;
  localparam logic [7:0] CH_LC_F      = 8'h66;
  localparam logic [7:0] CH_LC_N      = 8'h6E;
  localparam logic [7:0] CH_LC_R      = 8'h72;
  localparam logic [7:0] CH_LC_T      = 8'h74;
  localparam logic [7:0] CH_LC_V      = 8'h76;
  localparam logic [7:0] CH_UC_A      = 8'h41;
  localparam logic [7:0] CH_UC_F      = 8'h46;

  // Control codes produced by the letter escapes.
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;

  // Digit run lengths.
  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // One decoded result.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  // Up to two results produced by one accepted character.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] m;
    unique case (c)
      CH_LC_A: m = CODE_BEL;
      CH_LC_B: m = CODE_BS;
      CH_LC_F: m = CODE_FF;
      CH_LC_N: m = CODE_LF;
      CH_LC_R: m = CODE_CR;
      CH_LC_T: m = CODE_TAB;
      CH_LC_V: m = CODE_VT;
      default: m = c;
    endcase
    return m;
  endfunction

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== src/esd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic           kind,
  input  wire logic [7:0]     ch,
  output esd_pkg::push_t      push
);
  import esd_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [8:0] accum_r, accum_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic       is_end;
  logic       is_bs;
  logic       oct_ok;
  hex_t       hx;
  logic       hex_ok;
  logic [8:0] oct_acc;
  logic [8:0] hex_acc;
  logic [1:0] cnt_inc;
  logic       run_set;
  res_t       term_res;
  res_t       char_res;

  assign is_end   = kind | (ch == CH_NUL);
  assign is_bs    = !is_end && (ch == CH_BACKSLASH);
  assign oct_ok   = !is_end && (ch >= CH_ZERO) && (ch <= CH_SEVEN);
  assign hx       = hex_decode(ch);
  assign hex_ok   = !is_end && hx.ok;
  assign oct_acc  = {accum_r[5:0], ch[2:0]};
  assign hex_acc  = {accum_r[4:0], hx.val};
  assign cnt_inc  = cnt_r + 2'd1;
  assign run_set  = (cnt_r != 2'd0);
  assign term_res = '{data: CH_NUL, last: 1'b1};
  assign char_res = '{data: ch, last: 1'b0};

  // Next state.
  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    cnt_nxt   = cnt_r;
    if (fire) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (is_bs) mode_nxt = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          accum_nxt = 9'd0;
          cnt_nxt   = 2'd0;
          if (is_end) begin
            mode_nxt = MODE_NORMAL;
          end else if (ch == CH_ZERO) begin
            mode_nxt = MODE_OCTAL;
          end else if (ch == CH_X) begin
            mode_nxt = MODE_HEX;
          end else begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_OCTAL: begin
          if (oct_ok && cnt_inc != OCT_DIGITS) begin
            accum_nxt = oct_acc;
            cnt_nxt   = cnt_inc;
          end else begin
            accum_nxt = 9'd0;
            cnt_nxt   = 2'd0;
            mode_nxt  = (!oct_ok && is_bs) ? MODE_ESCAPE : MODE_NORMAL;
          end
        end
        MODE_HEX: begin
          if (hex_ok && cnt_inc != HEX_DIGITS) begin
            accum_nxt = hex_acc;
            cnt_nxt   = cnt_inc;
          end else begin
            accum_nxt = 9'd0;
            cnt_nxt   = 2'd0;
            mode_nxt  = (!hex_ok && is_bs) ? MODE_ESCAPE : MODE_NORMAL;
          end
        end
        default: mode_nxt = MODE_NORMAL;
      endcase
    end
  end

  // Results. A second result only appears when a digit run is closed by a
  // character that then produces its own output.
  always_comb begin
    push = '0;
    if (fire) begin
      unique case (mode_r)
        MODE_NORMAL: begin
          if (is_end) begin
            push.v0 = 1'b1;
            push.r0 = term_res;
          end else if (!is_bs) begin
            push.v0 = 1'b1;
            push.r0 = char_res;
          end
        end
        MODE_ESCAPE: begin
          if (is_end) begin
            push.v0 = 1'b1;
            push.r0 = term_res;
          end else if (ch != CH_ZERO && ch != CH_X) begin
            push.v0 = 1'b1;
            push.r0 = '{data: map_escape(ch), last: 1'b0};
          end
        end
        MODE_OCTAL: begin
          if (oct_ok) begin
            if (cnt_inc == OCT_DIGITS) begin
              push.v0 = 1'b1;
              push.r0 = '{data: oct_acc[7:0], last: 1'b0};
            end
          end else begin
            push.v0 = 1'b1;
            push.r0 = '{data: run_set ? accum_r[7:0] : CH_ZERO, last: 1'b0};
            push.v1 = !is_bs;
            push.r1 = is_end ? term_res : char_res;
          end
        end
        MODE_HEX: begin
          if (hex_ok) begin
            if (cnt_inc == HEX_DIGITS) begin
              push.v0 = 1'b1;
              push.r0 = '{data: hex_acc[7:0], last: 1'b0};
            end
          end else begin
            push.v0 = 1'b1;
            push.r0 = '{data: run_set ? accum_r[7:0] : CH_X, last: 1'b0};
            push.v1 = !is_bs;
            push.r1 = is_end ? term_res : char_res;
          end
        end
        default: push = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      accum_r <= 9'd0;
      cnt_r   <= 2'd0;
    end else begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/esd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire esd_pkg::push_t push,
  input  wire logic           pop,
  output logic                space,
  output logic                nonempty,
  output esd_pkg::res_t       head
);
  import esd_pkg::*;

  res_t              mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  // Room for the worst case of two results from the next character.
  assign space    = (cnt_r <= Q_CW'(Q_DEPTH - 2));
  assign nonempty = (cnt_r != '0);
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_AW'(push.v0) + Q_AW'(push.v1);
    rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
    cnt_nxt    = cnt_r + Q_CW'(push.v0) + Q_CW'(push.v1) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr_r] <= push.r0;
    if (push.v1) mem[wr_ptr_r + Q_AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/esd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_nonempty,
  input  wire esd_pkg::res_t  q_head,
  output logic                pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);
  import esd_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // Refill the output register whenever it is empty or being drained.
  assign pop = q_nonempty && (!valid_r || out_tready);

  always_comb begin
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= q_head;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.data;
  assign out_tlast  = res_r.last;

endmodule

`default_nettype wire

// ===== src/escape_sequence_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (low bit up)   tuser / tlast
// in_       slave      [7:0] ch             tuser: kind (1 = end of string)
// out_      master     [7:0] out_byte       tlast: is_end (terminator)
//
// One character is accepted per cycle while in_tready is high. The decoder front
// is combinational, so a result is registered first in the result queue and
// then in the output register; the second result of a character follows the
// first out of the queue.
// A character that closes a digit run and yields its own output pushes two
// results while the output drains at most one per cycle, so a run of such
// characters builds up the four-entry result queue and in_tready drops
// whenever fewer than two entries are free, until the output side catches up.
// Reset is synchronous and active low; it returns the decoder to normal mode
// and empties the queue and output register.

module escape_sequence_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input characters.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic       in_tuser,   // [0] kind
  // Decoded bytes.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast
);
  import esd_pkg::*;

  logic  in_fire;
  push_t push;
  logic  q_space;
  logic  q_nonempty;
  logic  q_pop;
  res_t  q_head;

  // The front only takes a character when the queue can hold both of the
  // results it might produce, so it never has to stall mid-transaction.
  assign in_tready = q_space;
  assign in_fire   = in_tvalid && in_tready;

  // Front: escape state machine that classifies each character and forms
  // zero, one or two results.
  esd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .kind  (in_tuser),
    .ch    (in_tdata),
    .push  (push)
  );

  // Short queue that decouples the decoder from output back-pressure.
  esd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (q_pop),
    .space    (q_space),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // Back: registered output stage that hands results to the consumer.
  esd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== src/esd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // The terminator always carries a zero byte.
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 8'h00)
    else $error("terminator with nonzero byte");

  // Reset empties the output stage.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // Reset leaves the queue empty, so the input side is ready at once.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (.*);

`default_nettype wire
